/* sv/ifde_pkg.sv */
// shared types, constants and duration helper for the ir frame duration encoder
`timescale 1ns / 1ps
`default_nettype none
package ifde_pkg;

  localparam int TU_W    = 10;
  localparam int CODE_W  = 8;
  localparam int DUR_W   = 16;
  localparam int MULT_W  = 8;
  localparam int PROD_W  = TU_W + MULT_W;
  localparam int FRAME_W = 48;
  localparam int PAIRS   = 50;
  localparam int IDX_W   = $clog2(PAIRS);

  localparam logic [TU_W-1:0] TU_RESET = TU_W'(432);

  localparam longint MAX_DURATION = 65535;
  localparam logic [DUR_W-1:0] DUR_CAP =
    (MAX_DURATION > 65535) ? {DUR_W{1'b1}} : DUR_W'(MAX_DURATION);

  localparam logic [MULT_W-1:0] HDR_MARK  = MULT_W'(8);
  localparam logic [MULT_W-1:0] HDR_SPACE = MULT_W'(4);
  localparam logic [MULT_W-1:0] ONE_SPACE = MULT_W'(3);
  localparam logic [MULT_W-1:0] UNIT      = MULT_W'(1);
  localparam logic [MULT_W-1:0] TRL_SPACE = MULT_W'(173);

  localparam logic [CODE_W-1:0] BYTE_LEAD = CODE_W'(2);
  localparam logic [CODE_W-1:0] BYTE_VEND = CODE_W'(32);

  localparam int QUEUE_DEPTH = 2;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [IDX_W-1:0]   pair_idx_t;

  // head of the command queue as seen by the sequencer
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } qhead_t;

  function automatic logic [DUR_W-1:0] duration(logic [TU_W-1:0] tu,
                                                logic [MULT_W-1:0] mult);
    logic [PROD_W-1:0] prod;
    prod = tu * mult;
    if (prod > PROD_W'(DUR_CAP)) begin
      return DUR_CAP;
    end
    return prod[DUR_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/ifde_front.sv */
// front end: accepts a command and builds the 48-bit frame word
`timescale 1ns / 1ps
`default_nettype none
module ifde_front (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ifde_pkg::CODE_W-1:0]   device_code,
  input  wire logic [ifde_pkg::CODE_W-1:0]   subdevice_code,
  input  wire logic [ifde_pkg::CODE_W-1:0]   function_code,
  input  wire logic                          q_full,
  output logic                               push,
  output ifde_pkg::frame_t                   push_frame
);

  logic [ifde_pkg::CODE_W-1:0] check;

  always_comb begin
    check      = device_code ^ subdevice_code ^ function_code;
    in_stall   = q_full;
    push       = in_valid && !q_full;
    push_frame = {check, function_code, subdevice_code, device_code,
                  ifde_pkg::BYTE_VEND, ifde_pkg::BYTE_LEAD};
  end

endmodule
`default_nettype wire

/* sv/ifde_queue.sv */
// short frame queue between front end and pair sequencer
`timescale 1ns / 1ps
`default_nettype none
module ifde_queue #(
  parameter int DEPTH = ifde_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ifde_pkg::frame_t push_frame,
  output logic                  full,
  input  wire logic             pop,
  output ifde_pkg::qhead_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ifde_pkg::frame_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_comb begin
    full       = (count == CNT_W'(DEPTH));
    head.valid = (count != '0);
    head.frame = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/ifde_back.sv */
// back end: walks one frame and emits a mark/space pair per cycle while out_stall is low
`timescale 1ns / 1ps
`default_nettype none
module ifde_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ifde_pkg::TU_W-1:0]     time_unit,
  input  wire ifde_pkg::qhead_t              head,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ifde_pkg::DUR_W-1:0]         mark_time,
  output logic [ifde_pkg::DUR_W-1:0]         space_time,
  output logic                               frame_end
);

  localparam ifde_pkg::pair_idx_t LAST = ifde_pkg::IDX_W'(ifde_pkg::PAIRS - 1);

  logic                           active;
  ifde_pkg::pair_idx_t            idx;
  ifde_pkg::frame_t               frame;
  logic                           can_load;
  logic                           last_pair;
  logic [ifde_pkg::MULT_W-1:0]    mark_mult;
  logic [ifde_pkg::MULT_W-1:0]    space_mult;

  always_comb begin
    can_load  = !out_valid || !out_stall;
    last_pair = (idx == LAST);
    pop       = head.valid && (!active || (can_load && last_pair));
    mark_mult = ifde_pkg::UNIT;
    if (idx == '0) begin
      mark_mult  = ifde_pkg::HDR_MARK;
      space_mult = ifde_pkg::HDR_SPACE;
    end else if (last_pair) begin
      space_mult = ifde_pkg::TRL_SPACE;
    end else begin
      space_mult = frame[0] ? ifde_pkg::ONE_SPACE : ifde_pkg::UNIT;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (can_load && active) begin
      mark_time  <= ifde_pkg::duration(time_unit, mark_mult);
      space_time <= ifde_pkg::duration(time_unit, space_mult);
      frame_end  <= last_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame <= head.frame;
    end else if (can_load && active && idx != '0 && !last_pair) begin
      frame <= frame >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid <= active;
      end
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (can_load && active) begin
        if (last_pair) begin
          active <= 1'b0;
          idx    <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* sv/ir_frame_duration_encoder_unit.sv */
// top level of the ir frame duration encoder
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_stall     device_code, subdevice_code, function_code
//   out       output     out_valid / out_stall   mark_time, space_time, frame_end
//   cfg       input      cfg_valid / cfg_ready   cfg_data (time_unit)
//
// one command gives 50 words, one per cycle from the pair sequencer while out_stall
// is low; the sequencer sets the sustained rate
// commands enter the two-entry queue in any cycle it has room; when the sequencer is
// free, the first word goes from the queue through the sequencer to the output register
// rst is synchronous and restores time_unit to 432 and empties the queue
// out_stall holds the output word and the sequencer; in_stall rises only on a full queue
`timescale 1ns / 1ps
`default_nettype none
module ir_frame_duration_encoder_unit #(
  parameter int QUEUE_DEPTH = ifde_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ifde_pkg::CODE_W-1:0]   device_code,
  input  wire logic [ifde_pkg::CODE_W-1:0]   subdevice_code,
  input  wire logic [ifde_pkg::CODE_W-1:0]   function_code,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ifde_pkg::DUR_W-1:0]         mark_time,
  output logic [ifde_pkg::DUR_W-1:0]         space_time,
  output logic                               frame_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ifde_pkg::TU_W-1:0]     cfg_data
);

  logic [ifde_pkg::TU_W-1:0] time_unit;
  logic                      q_full;
  logic                      push;
  ifde_pkg::frame_t          push_frame;
  logic                      pop;
  ifde_pkg::qhead_t          head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_unit <= ifde_pkg::TU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      time_unit <= cfg_data;
    end
  end

  ifde_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .device_code    (device_code),
    .subdevice_code (subdevice_code),
    .function_code  (function_code),
    .q_full         (q_full),
    .push           (push),
    .push_frame     (push_frame)
  );

  ifde_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  ifde_back u_back (
    .clk        (clk),
    .rst        (rst),
    .time_unit  (time_unit),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .mark_time  (mark_time),
    .space_time (space_time),
    .frame_end  (frame_end)
  );

endmodule
`default_nettype wire
